// ===== rtl/core/afs_pkg.sv =====
// ----------------------------------------------------------------------------
// afs_pkg: shared types and helpers of the animation frame sequencer
// Holds the play mode codes, the sequencer state record and the small frame
// arithmetic helpers used by the step logic and the command logic.
// ----------------------------------------------------------------------------
package afs_pkg;

  // Largest number of frames in one range; a requested count is clamped to it.
  localparam int MAX_FRAMES = 512;
  localparam logic [10:0] MAX_FRAMES_W = 11'(MAX_FRAMES);

  // Highest frame index a computed range end may reach.
  localparam logic [11:0] FRAME_TOP = 12'd1023;

  // Reset value of the queued range base: all ones marks "no queue".
  localparam logic [9:0] QUEUE_BASE_NONE = 10'h3FF;

  // Input stream payload layout.
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic [2:0] {
    MODE_HOLD    = 3'd0,
    MODE_TRIGGER = 3'd1,
    MODE_CYCLE   = 3'd2,
    MODE_TRAVEL  = 3'd3,
    MODE_BOUNCE  = 3'd4,
    MODE_NONE    = 3'd5
  } mode_t;

  // Command carried in the input tuser bit.
  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_SET  = 1'b1
  } cmd_t;

  typedef struct packed {
    logic        [9:0]  range_base;
    logic        [9:0]  range_last;
    logic signed [10:0] frame_now;
    logic signed [10:0] frame_next;
    mode_t              play_mode;
    logic               step_neg;
    logic        [15:0] time_left;
    logic        [15:0] period;
    logic        [9:0]  queue_base;
    logic        [9:0]  queue_last;
    logic               queue_pending;
  } afs_state_t;

  // One decoded input item.
  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] elapsed;
    logic        trigger_held;
    logic [8:0]  start_frame;
    logic [9:0]  frame_count;
    logic [2:0]  mode;
    logic [15:0] frame_period;
    logic        queued_valid;
    logic [8:0]  queued_start;
    logic [9:0]  queued_count;
  } afs_item_t;

  // One result item.
  typedef struct packed {
    logic [9:0] current_frame;
    logic [9:0] next_frame;
    logic       changed;
  } afs_result_t;

  // A range bound viewed as a signed frame number.
  function automatic logic signed [10:0] to_frame(input logic [9:0] b);
    return $signed({1'b0, b});
  endfunction

  // One step forward or backward, wrapping in 11-bit two's complement.
  function automatic logic signed [10:0] step11(input logic signed [10:0] v,
                                                input logic neg);
    return neg ? v - 11'sd1 : v + 11'sd1;
  endfunction

  function automatic logic frame_gt(input logic signed [10:0] f,
                                    input logic [9:0] b);
    return $signed({f[10], f}) > $signed({2'b00, b});
  endfunction

  function automatic logic frame_lt(input logic signed [10:0] f,
                                    input logic [9:0] b);
    return $signed({f[10], f}) < $signed({2'b00, b});
  endfunction

  // Last frame of a range: count clamped to 1..MAX_FRAMES, end saturated.
  function automatic logic [9:0] range_end(input logic [9:0] start,
                                           input logic [9:0] count);
    logic [10:0] c;
    logic [11:0] e;
    c = {1'b0, count};
    if (c == 11'd0) begin
      c = 11'd1;
    end else if (c > MAX_FRAMES_W) begin
      c = MAX_FRAMES_W;
    end
    e = {2'b00, start} + {1'b0, c} - 12'd1;
    return (e > FRAME_TOP) ? 10'h3FF : e[9:0];
  endfunction

endpackage

// ===== rtl/core/afs_frame_step.sv =====
// ----------------------------------------------------------------------------
// afs_frame_step: one frame advance
// Applies the play mode rule to the sequencer state when the frame timer runs
// out. Purely combinational; the caller decides whether to keep the result.
// ----------------------------------------------------------------------------
module afs_frame_step
  import afs_pkg::*;
(
  input  afs_state_t cur_i,
  input  logic       trigger_held_i,
  output afs_state_t nxt_o
);

  logic signed [10:0] fn;
  logic signed [10:0] fx;
  logic        [9:0]  base_v;
  logic        [9:0]  last_v;
  logic signed [11:0] span;

  assign span = $signed({2'b00, cur_i.range_last}) - $signed({2'b00, cur_i.range_base});

  always_comb begin
    nxt_o  = cur_i;
    fn     = step11(cur_i.frame_now, cur_i.step_neg);
    fx     = cur_i.frame_next;
    base_v = cur_i.range_base;
    last_v = cur_i.range_last;
    if (span <= 12'sd1) begin
      // Ranges of one or two frames just sit on the base frame.
      nxt_o.frame_now  = to_frame(cur_i.range_base);
      nxt_o.frame_next = to_frame(cur_i.range_base);
    end else begin
      case (cur_i.play_mode)
        MODE_HOLD: begin
          nxt_o.frame_next = cur_i.frame_now;
        end
        MODE_TRIGGER: begin
          if (frame_gt(fn, last_v)) begin
            fn = to_frame(base_v);
          end
          if (trigger_held_i) begin
            fx = step11(fn, cur_i.step_neg);
            if (frame_gt(fx, last_v)) begin
              fx = to_frame(base_v);
            end
            if (frame_lt(fx, base_v)) begin
              fx = to_frame(last_v);
            end
          end else begin
            // Release: jump to the queued range, cycling only if one was queued.
            nxt_o.range_base    = cur_i.queue_base;
            nxt_o.range_last    = cur_i.queue_last;
            nxt_o.play_mode     = cur_i.queue_pending ? MODE_CYCLE : MODE_NONE;
            nxt_o.queue_pending = 1'b0;
            fn = to_frame(cur_i.queue_base);
            fx = step11(fn, cur_i.step_neg);
            if (frame_gt(fx, cur_i.queue_last)) begin
              fx = to_frame(cur_i.queue_last);
            end
          end
          nxt_o.frame_now  = fn;
          nxt_o.frame_next = fx;
        end
        MODE_CYCLE: begin
          if (frame_gt(fn, last_v)) begin
            fn = to_frame(base_v);
            if (cur_i.queue_pending) begin
              base_v = cur_i.queue_base;
              last_v = cur_i.queue_last;
              fn     = to_frame(cur_i.queue_base);
              nxt_o.queue_pending = 1'b0;
            end
          end
          fx = step11(fn, cur_i.step_neg);
          if (frame_gt(fx, last_v)) begin
            fx = to_frame(base_v);
          end
          if (frame_lt(fx, base_v)) begin
            fx = to_frame(last_v);
          end
          nxt_o.range_base = base_v;
          nxt_o.range_last = last_v;
          nxt_o.frame_now  = fn;
          nxt_o.frame_next = fx;
        end
        MODE_TRAVEL: begin
          if (frame_gt(fn, last_v) || frame_lt(fn, base_v)) begin
            fn = cur_i.step_neg ? to_frame(base_v) : to_frame(last_v);
            fx = fn;
          end else begin
            fx = step11(fn, cur_i.step_neg);
            if (frame_gt(fx, last_v)) begin
              fx = to_frame(last_v);
            end
            if (frame_lt(fx, base_v)) begin
              fx = to_frame(base_v);
            end
          end
          nxt_o.frame_now  = fn;
          nxt_o.frame_next = fx;
        end
        MODE_BOUNCE: begin
          // Reflect off either end; the interpolation target stays put.
          if (!cur_i.step_neg) begin
            if (frame_gt(fn, last_v)) begin
              fn = to_frame(last_v) - 11'sd1;
              nxt_o.step_neg = 1'b1;
            end
          end else if (frame_lt(fn, base_v)) begin
            fn = to_frame(base_v) + 11'sd1;
            nxt_o.step_neg = 1'b0;
          end
          nxt_o.frame_now = fn;
        end
        default: begin
          // None and unused codes leave the frames alone.
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/afs_seq.sv =====
// ----------------------------------------------------------------------------
// afs_seq: sequencer state and command decode
// Holds the sequencer state and applies one set or tick item per enabled
// cycle, producing the result fields from the updated state.
// ----------------------------------------------------------------------------
module afs_seq
  import afs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_en_i,
  input  afs_item_t   item_i,
  output afs_result_t result_o
);

  afs_state_t st_r;
  afs_state_t st_nxt;
  afs_state_t step_st;
  logic       changed;

  afs_frame_step u_step (
    .cur_i          (st_r),
    .trigger_held_i (item_i.trigger_held),
    .nxt_o          (step_st)
  );

  always_comb begin
    st_nxt  = st_r;
    changed = 1'b0;
    case (item_i.cmd)
      CMD_SET: begin
        // A set whose start matches the current base is ignored.
        if ({1'b0, item_i.start_frame} != st_r.range_base) begin
          st_nxt.range_base    = {1'b0, item_i.start_frame};
          st_nxt.range_last    = range_end({1'b0, item_i.start_frame},
                                           item_i.frame_count);
          st_nxt.frame_now     = to_frame({1'b0, item_i.start_frame});
          st_nxt.play_mode     = mode_t'(item_i.mode);
          st_nxt.period        = item_i.frame_period;
          st_nxt.time_left     = 16'd0;
          st_nxt.queue_pending = item_i.queued_valid;
          if (item_i.queued_valid) begin
            st_nxt.queue_base = {1'b0, item_i.queued_start};
            st_nxt.queue_last = range_end({1'b0, item_i.queued_start},
                                          item_i.queued_count);
          end
          changed = 1'b1;
        end
      end
      CMD_TICK: begin
        if (st_r.time_left > item_i.elapsed) begin
          st_nxt.time_left = st_r.time_left - item_i.elapsed;
        end else begin
          st_nxt           = step_st;
          st_nxt.time_left = st_r.period;
          changed          = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign result_o.current_frame = st_nxt.frame_now[9:0];
  assign result_o.next_frame    = st_nxt.frame_next[9:0];
  assign result_o.changed       = changed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.range_base    <= 10'd0;
      st_r.range_last    <= 10'd0;
      st_r.frame_now     <= 11'sd0;
      st_r.frame_next    <= 11'sd0;
      st_r.play_mode     <= MODE_HOLD;
      st_r.step_neg      <= 1'b0;
      st_r.time_left     <= 16'd0;
      st_r.period        <= 16'd0;
      st_r.queue_base    <= QUEUE_BASE_NONE;
      st_r.queue_last    <= 10'd0;
      st_r.queue_pending <= 1'b0;
    end else if (item_en_i) begin
      st_r <= st_nxt;
    end
  end

endmodule

// ===== rtl/core/animation_frame_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// animation_frame_sequencer_core: keyframe animation frame sequencer
// Takes set and tick commands on a stream input and returns the shown frame,
// the interpolation target and a change flag for every command.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Transfers               | Handshake
//   --------+-----------+-------------------------+-------------------------
//   in_     | slave     | one set or tick command | in_tvalid / in_tready
//   out_    | master    | one result per command  | out_tvalid / out_tready
//
// Each command is held in the input register and its result then sits in
// the output register. Throughput is one command per cycle while out_tready
// is high, set by the single state update of afs_seq.
// Reset (rst_n low at a clock edge) empties both registers and restores the
// sequencer state: hold mode, frame 0, no queued range.
// When the output is stalled the input register holds its command and the
// input keeps taking transfers only while the input register is free.
// ----------------------------------------------------------------------------
module animation_frame_sequencer_core
  import afs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [15:0] elapsed, [16] trigger_held, [25:17] start_frame, [35:26] frame_count,
  // [38:36] mode, [54:39] frame_period, [55] queued_valid, [64:56] queued_start,
  // [74:65] queued_count, [79:75] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [0] cmd (0 tick, 1 set)
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [9:0] current_frame, [19:10] next_frame, [20] changed, [23:21] zero
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic        in_valid_r;
  afs_item_t   item_r;
  afs_item_t   item_nxt;
  logic        advance;
  afs_result_t result;
  afs_result_t result_r;
  logic        out_valid_r;
  logic        out_valid_nxt;

  // The held command moves into the result register whenever that register
  // is empty or being drained in the same cycle.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  assign item_nxt.cmd          = cmd_t'(in_tuser);
  assign item_nxt.elapsed      = in_tdata[15:0];
  assign item_nxt.trigger_held = in_tdata[16];
  assign item_nxt.start_frame  = in_tdata[25:17];
  assign item_nxt.frame_count  = in_tdata[35:26];
  assign item_nxt.mode         = in_tdata[38:36];
  assign item_nxt.frame_period = in_tdata[54:39];
  assign item_nxt.queued_valid = in_tdata[55];
  assign item_nxt.queued_start = in_tdata[64:56];
  assign item_nxt.queued_count = in_tdata[74:65];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= item_nxt;
    end
  end

  // The state update and the result are computed together from the held
  // command, so the state advances exactly once per delivered result.
  afs_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_en_i (advance),
    .item_i    (item_r),
    .result_o  (result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, result_r.changed, result_r.next_frame,
                       result_r.current_frame};

`ifndef SYNTHESIS
  // A command moved forward always shows up as a pending result.
  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_tvalid)
    else $error("result missing after advance");

  // A result taken with nothing behind it must not be shown again.
  a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !advance) |=> !out_tvalid)
    else $error("result repeated");

  // An empty output stage never blocks the input.
  a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // A held command that cannot advance stays in the input register.
  a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !advance) |=> in_valid_r)
    else $error("held command lost");

  // Reset empties both pipeline registers.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && !in_valid_r))
    else $error("pipeline not empty after reset");
`endif

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking testbench for the animation frame sequencer core
// Drives set and tick commands through the input stream and checks every
// result on the output stream against a cycle-free predictor of the
// sequencer. A short directed table comes first, then random command runs.
// ----------------------------------------------------------------------------
module tb
  import afs_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Mode codes the block has no rule for; they behave as "none".
  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;

  // A result typed into the table, used instead of the predicted one.
  typedef struct packed {
    logic        chk;
    afs_result_t res;
  } pinned_t;

  typedef struct packed {
    afs_item_t item;
    pinned_t   pin;
  } stim_row_t;

  localparam pinned_t UNPINNED = '0;

  // Directed table. Column order of each item:
  //   cmd, elapsed, trigger_held, start_frame, frame_count, mode,
  //   frame_period, queued_valid, queued_start, queued_count
  // followed by the pinned result {chk, {current_frame, next_frame, changed}}.
  localparam int DIRECTED_N = 29;
  localparam stim_row_t DIRECTED [DIRECTED_N] = '{
    // First tick after reset: one-frame range, both frames land on base 0.
    '{'{CMD_TICK, 0, 0, 0, 0, MODE_HOLD, 0, 0, 0, 0}, '{1, '{0, 0, 1}}},
    // A set whose start equals the current base is refused.
    '{'{CMD_SET, 0, 0, 0, 1, MODE_HOLD, 0, 0, 0, 0}, '{1, '{0, 0, 0}}},
    // Accepted set: current jumps to the start, next is left alone.
    '{'{CMD_SET, 0, 0, 10, 20, MODE_CYCLE, 100, 1, 100, 5}, '{1, '{10, 0, 1}}},
    '{'{CMD_TICK, 0, 1, 0, 0, MODE_HOLD, 0, 0, 0, 0}, UNPINNED},
    '{'{CMD_TICK, 50, 1, 0, 0, MODE_HOLD, 0, 0, 0, 0}, UNPINNED},
    '{'{CMD_TICK, 65535, 1, 0, 0, MODE_HOLD, 0, 0, 0, 0}, UNPINNED},
    // Short cycle without a queue: wraps back to its own base.
    '{'{CMD_SET, 0, 0, 27, 3, MODE_CYCLE, 0, 0, 0, 0}, UNPINNED},
    '{'{CMD_TICK, 0, 1, 0, 0, MODE_HOLD, 0, 0, 0, 0}, UNPINNED},
    '{'{CMD_TICK, 0, 1, 0, 0, MODE_HOLD, 0, 0, 0, 0}, UNPINNED},
    '{'{CMD_TICK, 0, 1, 0, 0, MODE_HOLD, 0, 0, 0, 0}, UNPINNED},
    // Widest range at the top start frame, longest period.
    '{'{CMD_SET, 0, 0, 511, 512, MODE_TRAVEL, 65535, 0, 0, 0}, UNPINNED},
    '{'{CMD_TICK, 0, 1, 0, 0, MODE_HOLD, 0, 0, 0, 0}, UNPINNED},
    '{'{CMD_TICK, 65535, 1, 0, 0, MODE_HOLD, 0, 0, 0, 0}, UNPINNED},
    // Bounce over a three-frame range: reflects at the top and walks back to the base.
    '{'{CMD_SET, 0, 0, 5, 3, MODE_BOUNCE, 0, 0, 0, 0}, UNPINNED},
    '{'{CMD_TICK, 0, 1, 0, 0, MODE_HOLD, 0, 0, 0, 0}, UNPINNED},
    '{'{CMD_TICK, 0, 1, 0, 0, MODE_HOLD, 0, 0, 0, 0}, UNPINNED},
    '{'{CMD_TICK, 0, 1, 0, 0, MODE_HOLD, 0, 0, 0, 0}, UNPINNED},
    '{'{CMD_TICK, 0, 1, 0, 0, MODE_HOLD, 0, 0, 0, 0}, UNPINNED},
    // Trigger with a queued range clamped to the largest count.
    '{'{CMD_SET, 0, 0, 40, 4, MODE_TRIGGER, 0, 1, 511, 1023}, UNPINNED},
    '{'{CMD_TICK, 0, 1, 0, 0, MODE_HOLD, 0, 0, 0, 0}, UNPINNED},
    '{'{CMD_TICK, 0, 0, 0, 0, MODE_HOLD, 0, 0, 0, 0}, UNPINNED},
    // Trigger released with no queue: the stale queue range is taken up.
    '{'{CMD_SET, 0, 0, 60, 4, MODE_TRIGGER, 0, 0, 0, 0}, UNPINNED},
    '{'{CMD_TICK, 0, 0, 0, 0, MODE_HOLD, 0, 0, 0, 0}, UNPINNED},
    // Undefined mode codes act as "none".
    '{'{CMD_SET, 0, 0, 3, 5, MODE_SPARE6, 0, 0, 0, 0}, UNPINNED},
    '{'{CMD_TICK, 0, 1, 0, 0, MODE_HOLD, 0, 0, 0, 0}, UNPINNED},
    '{'{CMD_SET, 0, 0, 100, 1023, MODE_SPARE7, 0, 1, 0, 0}, UNPINNED},
    '{'{CMD_TICK, 0, 1, 0, 0, MODE_HOLD, 0, 0, 0, 0}, UNPINNED},
    // A zero frame count is clamped to one frame, a short range.
    '{'{CMD_SET, 0, 0, 200, 0, MODE_HOLD, 0, 0, 0, 0}, UNPINNED},
    '{'{CMD_TICK, 0, 1, 0, 0, MODE_HOLD, 0, 0, 0, 0}, UNPINNED}
  };

  // The random part stops once this many items are counted; repeated-start sets are not counted.
  localparam int RANDOM_ITEMS = 950;
  // Cycles the receiver holds off when asked for a long stall.
  localparam int LONG_STALL = 80;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  animation_frame_sequencer_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  // Shadow of the sequencer state. Frames are kept as plain integers holding
  // the signed 11-bit value, so every compare with base and last is signed.
  int          seq_base = 0;
  int          seq_last = 0;
  int          pos_now = 0;
  int          pos_next = 0;
  logic [2:0]  seq_mode = MODE_HOLD;
  logic        reverse = 1'b0;
  int          remaining = 0;
  int          frame_time = 0;
  int          q_base = int'(QUEUE_BASE_NONE);
  int          q_last = 0;
  logic        q_armed = 1'b0;

  // Results still owed by the block, oldest first, and the pinned
  // expectations of items that have been offered but not yet transferred.
  afs_result_t frame_expect_q[$];
  pinned_t     pinned_q[$];

  int errors = 0;
  // The sender bumps stall_asks; the receiver answers each with one long stall.
  int stall_asks = 0;

  // Frame arithmetic wraps in 11-bit two's complement.
  function automatic int wrap11(input int v);
    logic [10:0] u;
    u = v[10:0];
    return $signed(u);
  endfunction

  // Last frame of a range: the count is clamped to 1..MAX_FRAMES and the end
  // saturates at the top frame index.
  function automatic int range_stop(input int start, input int count);
    int c;
    c = count;
    if (c < 1) c = 1;
    if (c > MAX_FRAMES) c = MAX_FRAMES;
    c = start + c - 1;
    return (c > int'(FRAME_TOP)) ? int'(FRAME_TOP) : c;
  endfunction

  // Applies one command to the shadow state and returns the result it causes.
  function automatic afs_result_t sequence_advance(input afs_item_t it);
    int          dir;
    int          lo;
    int          hi;
    logic        chg;
    afs_result_t r;
    chg = 1'b0;
    if (it.cmd == CMD_SET) begin
      if (int'(it.start_frame) != seq_base) begin
        seq_base   = it.start_frame;
        seq_last   = range_stop(it.start_frame, it.frame_count);
        pos_now    = it.start_frame;
        seq_mode   = it.mode;
        frame_time = it.frame_period;
        remaining  = 0;
        q_armed    = 1'b0;
        // Without a queue the old queue bounds stay in place.
        if (it.queued_valid) begin
          q_base  = it.queued_start;
          q_last  = range_stop(it.queued_start, it.queued_count);
          q_armed = 1'b1;
        end
        chg = 1'b1;
      end
    end else if (remaining > int'(it.elapsed)) begin
      remaining = remaining - int'(it.elapsed);
    end else begin
      remaining = frame_time;
      chg = 1'b1;
      lo  = seq_base;
      hi  = seq_last;
      dir = reverse ? -1 : 1;
      if (hi - lo <= 1) begin
        // Ranges of one or two frames pin both frames to the base.
        pos_now  = lo;
        pos_next = lo;
      end else begin
        case (seq_mode)
          MODE_HOLD: begin
            pos_next = pos_now;
          end
          MODE_TRIGGER: begin
            pos_now = wrap11(pos_now + dir);
            if (pos_now > hi) pos_now = lo;
            if (it.trigger_held) begin
              pos_next = wrap11(pos_now + dir);
              if (pos_next > hi) pos_next = lo;
              if (pos_next < lo) pos_next = hi;
            end else begin
              // Release: move to the queued range, cycling only if one was set.
              seq_base = q_base;
              seq_last = q_last;
              seq_mode = q_armed ? MODE_CYCLE : MODE_NONE;
              pos_now  = seq_base;
              pos_next = wrap11(pos_now + dir);
              if (pos_next > seq_last) pos_next = seq_last;
              q_armed  = 1'b0;
            end
          end
          MODE_CYCLE: begin
            pos_now = wrap11(pos_now + dir);
            if (pos_now > hi) begin
              pos_now = lo;
              if (q_armed) begin
                seq_base = q_base;
                seq_last = q_last;
                pos_now  = seq_base;
                q_armed  = 1'b0;
              end
            end
            pos_next = wrap11(pos_now + dir);
            if (pos_next > seq_last) pos_next = seq_base;
            if (pos_next < seq_base) pos_next = seq_last;
          end
          MODE_TRAVEL: begin
            pos_now = wrap11(pos_now + dir);
            if (pos_now > hi || pos_now < lo) begin
              pos_now  = (dir < 0) ? lo : hi;
              pos_next = pos_now;
            end else begin
              pos_next = wrap11(pos_now + dir);
              if (pos_next > hi) pos_next = hi;
              if (pos_next < lo) pos_next = lo;
            end
          end
          MODE_BOUNCE: begin
            // The interpolation target is left alone while bouncing.
            pos_now = wrap11(pos_now + dir);
            if (dir > 0) begin
              if (pos_now > hi) begin
                pos_now = wrap11(hi - 1);
                reverse = 1'b1;
              end
            end else if (pos_now < lo) begin
              pos_now = wrap11(lo + 1);
              reverse = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
    end
    r.current_frame = pos_now[9:0];
    r.next_frame    = pos_next[9:0];
    r.changed       = chg;
    return r;
  endfunction

  // Any command with every field drawn over its full width; the caller
  // then shapes the fields that matter.
  function automatic afs_item_t any_command();
    afs_item_t it;
    it.cmd          = cmd_t'($urandom_range(0, 1));
    it.elapsed      = 16'($urandom);
    it.trigger_held = 1'($urandom);
    it.start_frame  = 9'($urandom);
    it.frame_count  = 10'($urandom);
    it.mode         = 3'($urandom);
    it.frame_period = 16'($urandom);
    it.queued_valid = 1'($urandom);
    it.queued_start = 9'($urandom);
    it.queued_count = 10'($urandom);
    return it;
  endfunction

  // Sender state: a run of back-to-back transfers is drawn now and then.
  int send_calm = 0;

  // Offers one command on the input stream. It is entered and left just after
  // a falling edge; tvalid is only lowered when a gap is drawn, so a command
  // that follows without a gap keeps tvalid high through the edge.
  task automatic offer(input afs_item_t it, input pinned_t pin);
    int gap;
    if (send_calm > 0) begin
      gap = 0;
      send_calm--;
    end else if ($urandom_range(0, 24) == 0) begin
      gap = 0;
      send_calm = $urandom_range(10, 30);
    end else begin
      gap = $urandom_range(0, 3);
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pinned_q.push_back(pin);
    in_tuser  <= it.cmd;
    in_tdata  <= {5'd0, it.queued_count, it.queued_start, it.queued_valid,
                  it.frame_period, it.mode, it.frame_count, it.start_frame,
                  it.trigger_held, it.elapsed};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Stimulus: reset once, the directed table, then random command runs.
  initial begin : stimulus
    afs_item_t it;
    int        sent;
    int        ticks;
    int        roll;
    logic      stalled;
    logic      drained;
    logic [8:0] last_start;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = CMD_TICK;
    sent       = 0;
    stalled    = 1'b0;
    drained    = 1'b0;
    last_start = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < DIRECTED_N; i++) begin
      offer(DIRECTED[i].item, DIRECTED[i].pin);
    end

    // Most of the random part is a set followed by a run of ticks, so every
    // mode gets played well past its first frames. The rest is noise: stray
    // ticks and sets that repeat the previous start and are likely refused.
    while (sent < RANDOM_ITEMS) begin
      if (sent >= 300 && !stalled) begin
        // The receiver stops for a long stretch while commands keep coming,
        // which fills the block and stalls its input.
        stall_asks++;
        stalled = 1'b1;
      end
      if (sent >= 600 && !drained) begin
        // Hold off until every owed result has been transferred.
        in_tvalid <= 1'b0;
        while (frame_expect_q.size() != 0 || pinned_q.size() != 0) @(negedge clk);
        @(negedge clk);
        drained = 1'b1;
      end
      roll = $urandom_range(0, 9);
      it = any_command();
      if (roll == 0) begin
        it.cmd = CMD_SET;
        it.start_frame = last_start;
        offer(it, UNPINNED);
      end else if (roll == 1) begin
        it.cmd = CMD_TICK;
        offer(it, UNPINNED);
        sent++;
      end else begin
        it.cmd = CMD_SET;
        do it.start_frame = 9'($urandom); while (it.start_frame == last_start);
        if ($urandom_range(0, 3) != 0) it.frame_count = 10'($urandom_range(0, 16));
        if ($urandom_range(0, 7) != 0) begin
          it.mode = 3'($urandom_range(MODE_HOLD, MODE_BOUNCE));
        end else begin
          it.mode = 3'($urandom_range(MODE_NONE, MODE_SPARE7));
        end
        if ($urandom_range(0, 7) != 0) it.frame_period = 16'($urandom_range(0, 40));
        last_start = it.start_frame;
        offer(it, UNPINNED);
        sent++;
        ticks = $urandom_range(4, 24);
        repeat (ticks) begin
          it = any_command();
          it.cmd = CMD_TICK;
          if ($urandom_range(0, 7) != 0) it.elapsed = 16'($urandom_range(0, 48));
          it.trigger_held = ($urandom_range(0, 7) != 0);
          offer(it, UNPINNED);
          sent++;
        end
      end
    end
    in_tvalid <= 1'b0;

    // Let the last results drain, then a few more cycles for anything stray.
    while (frame_expect_q.size() != 0 || pinned_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Receiver: draws a hold-off before each result, answers long-stall asks
  // with a stretch counted here, and now and then takes results back to back.
  initial begin : receiver
    int gap;
    int calm;
    int stall_done;
    out_tready = 1'b0;
    calm       = 0;
    stall_done = 0;
    while (!rst_n) @(negedge clk);
    forever begin
      if (stall_asks != stall_done) begin
        stall_done++;
        gap = LONG_STALL;
      end else if (calm > 0) begin
        gap = 0;
        calm--;
      end else if ($urandom_range(0, 24) == 0) begin
        gap = 0;
        calm = $urandom_range(10, 30);
      end else begin
        gap = $urandom_range(0, 3);
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  // Both streams are watched at the rising edge. An input transfer advances
  // the shadow state and queues its result; an output transfer is checked
  // against the oldest queued result.
  always @(posedge clk) begin : watch
    afs_item_t   seen;
    pinned_t     pin;
    afs_result_t want;
    afs_result_t got;
    if (rst_n && in_tvalid && in_tready) begin
      seen.cmd          = cmd_t'(in_tuser);
      seen.elapsed      = in_tdata[15:0];
      seen.trigger_held = in_tdata[16];
      seen.start_frame  = in_tdata[25:17];
      seen.frame_count  = in_tdata[35:26];
      seen.mode         = in_tdata[38:36];
      seen.frame_period = in_tdata[54:39];
      seen.queued_valid = in_tdata[55];
      seen.queued_start = in_tdata[64:56];
      seen.queued_count = in_tdata[74:65];
      pin  = pinned_q.pop_front();
      want = sequence_advance(seen);
      // A typed-in result from the table takes the place of the prediction.
      frame_expect_q.push_back(pin.chk ? pin.res : want);
    end
    if (rst_n && out_tvalid && out_tready) begin
      got.current_frame = out_tdata[9:0];
      got.next_frame    = out_tdata[19:10];
      got.changed       = out_tdata[20];
      if (frame_expect_q.size() == 0) begin
        $error("result transfer with none expected: %h", out_tdata);
        errors++;
      end else begin
        want = frame_expect_q.pop_front();
        if (got.current_frame != want.current_frame) begin
          $error("current_frame: expected %0d, got %0d",
                 want.current_frame, got.current_frame);
          errors++;
        end
        if (got.next_frame != want.next_frame) begin
          $error("next_frame: expected %0d, got %0d", want.next_frame, got.next_frame);
          errors++;
        end
        if (got.changed != want.changed) begin
          $error("changed: expected %0d, got %0d", want.changed, got.changed);
          errors++;
        end
      end
    end
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #400_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
